// ===== src/hps_pkg.sv =====
// Shared constants and types of the host/port splitter.
`default_nettype none
package hps_pkg;

   // Longest string that can still be good.
   localparam int MAX_LEN = 1024;

   // Byte counter saturates at MAX_LEN + 1.
   localparam int POS_W = $clog2(MAX_LEN + 2);

   // Field widths of a verdict.
   localparam int LEN_W = 11;

   // Offset math width: wide enough for the counter and for the fields.
   localparam int CALC_W = (POS_W > LEN_W) ? POS_W : LEN_W;

   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       empty_req;
   } item_type;

   typedef struct packed {
      logic             status;
      logic             host_offset;
      logic [LEN_W-1:0] host_length;
      logic [LEN_W-1:0] port_offset;
      logic [LEN_W-1:0] port_length;
      logic             has_port;
   } verdict_type;

endpackage
`default_nettype wire

// ===== src/hps_if.sv =====
// Request and response channel interfaces of the host/port splitter.
`default_nettype none
interface hps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       empty_req;

   modport source (output valid, output data_byte, output last, output empty_req,
                   input ready);
   modport sink   (input valid, input data_byte, input last, input empty_req,
                   output ready);
endinterface

interface hps_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     status;
   logic                     host_offset;
   logic [hps_pkg::LEN_W-1:0] host_length;
   logic [hps_pkg::LEN_W-1:0] port_offset;
   logic [hps_pkg::LEN_W-1:0] port_length;
   logic                     has_port;

   modport source (output valid, output status, output host_offset, output host_length,
                   output port_offset, output port_length, output has_port,
                   input ready);
   modport sink   (input valid, input status, input host_offset, input host_length,
                   input port_offset, input port_length, input has_port,
                   output ready);
endinterface
`default_nettype wire

// ===== src/hps_parse.sv =====
// Per-string parse state and verdict logic of the host/port splitter.
`default_nettype none
module hps_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire hps_pkg::item_type    item,
   output      logic                 has_verdict,
   output      hps_pkg::verdict_type verdict
);

   typedef enum logic [2:0] {
      PH_START,
      PH_BR_HOST,
      PH_AFTER_RB,
      PH_BR_PORT,
      PH_PLAIN_HOST,
      PH_PLAIN_PORT
   } phase_type;

   phase_type                   phase_ff, phase_in, phase_nx;
   logic [hps_pkg::POS_W-1:0]   position_ff, position_in, position_nx;
   logic [hps_pkg::POS_W-1:0]   split_ff, split_in, split_nx;
   logic                        error_ff, error_in, error_nx;
   logic [hps_pkg::CALC_W-1:0]  n_w, s_w;
   logic [hps_pkg::CALC_W-1:0]  br_hlen, br_poff, br_plen, pl_poff, pl_plen;
   hps_pkg::verdict_type        bad_v;

   assign has_verdict = item.last | item.empty_req;

   // Next parse state for one byte
   always_comb begin
      phase_nx    = phase_ff;
      split_nx    = split_ff;
      error_nx    = error_ff | (position_ff >= hps_pkg::POS_W'(hps_pkg::MAX_LEN));
      position_nx = (position_ff <= hps_pkg::POS_W'(hps_pkg::MAX_LEN)) ?
                    position_ff + hps_pkg::POS_W'(1) : position_ff;
      if (!error_nx) begin
         unique case (phase_ff)
            PH_START: begin
               if (item.data_byte == hps_pkg::CHAR_LBRACKET) begin
                  phase_nx = PH_BR_HOST;
               end else if (item.data_byte == hps_pkg::CHAR_COLON) begin
                  error_nx = 1'b1;
               end else begin
                  phase_nx = PH_PLAIN_HOST;
               end
            end
            PH_BR_HOST: begin
               if (item.data_byte == hps_pkg::CHAR_RBRACKET) begin
                  if (position_ff == hps_pkg::POS_W'(1)) begin
                     error_nx = 1'b1;
                  end else begin
                     split_nx = position_ff;
                     phase_nx = PH_AFTER_RB;
                  end
               end
            end
            PH_AFTER_RB: begin
               if (item.data_byte == hps_pkg::CHAR_COLON) begin
                  phase_nx = PH_BR_PORT;
               end else begin
                  error_nx = 1'b1;
               end
            end
            PH_PLAIN_HOST: begin
               if (item.data_byte == hps_pkg::CHAR_COLON) begin
                  split_nx = position_ff;
                  phase_nx = PH_PLAIN_PORT;
               end
            end
            PH_BR_PORT, PH_PLAIN_PORT: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Offsets and lengths, wrapped to the field width
   assign n_w     = hps_pkg::CALC_W'(position_nx);
   assign s_w     = hps_pkg::CALC_W'(split_nx);
   assign br_hlen = s_w - hps_pkg::CALC_W'(1);
   assign br_poff = s_w + hps_pkg::CALC_W'(2);
   assign br_plen = n_w - s_w - hps_pkg::CALC_W'(2);
   assign pl_poff = s_w + hps_pkg::CALC_W'(1);
   assign pl_plen = n_w - s_w - hps_pkg::CALC_W'(1);

   always_comb begin
      bad_v        = '0;
      bad_v.status = hps_pkg::STATUS_BAD;
      verdict      = bad_v;
      if (!item.empty_req && !error_nx) begin
         unique case (phase_nx)
            PH_AFTER_RB: begin
               verdict             = '0;
               verdict.host_offset = 1'b1;
               verdict.host_length = br_hlen[hps_pkg::LEN_W-1:0];
            end
            PH_BR_PORT: begin
               verdict             = '0;
               verdict.host_offset = 1'b1;
               verdict.host_length = br_hlen[hps_pkg::LEN_W-1:0];
               verdict.port_offset = br_poff[hps_pkg::LEN_W-1:0];
               verdict.port_length = br_plen[hps_pkg::LEN_W-1:0];
               verdict.has_port    = 1'b1;
            end
            PH_PLAIN_HOST: begin
               verdict             = '0;
               verdict.host_length = n_w[hps_pkg::LEN_W-1:0];
            end
            PH_PLAIN_PORT: begin
               verdict             = '0;
               verdict.host_length = s_w[hps_pkg::LEN_W-1:0];
               verdict.port_offset = pl_poff[hps_pkg::LEN_W-1:0];
               verdict.port_length = pl_plen[hps_pkg::LEN_W-1:0];
               verdict.has_port    = 1'b1;
            end
            default: begin
               verdict = bad_v;
            end
         endcase
      end
   end

   // State commits only when a byte is taken; a verdict clears it
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      split_in    = split_ff;
      error_in    = error_ff;
      if (fire) begin
         if (has_verdict) begin
            phase_in    = PH_START;
            position_in = '0;
            split_in    = '0;
            error_in    = 1'b0;
         end else begin
            phase_in    = phase_nx;
            position_in = position_nx;
            split_in    = split_nx;
            error_in    = error_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         position_ff <= '0;
         split_ff    <= '0;
         error_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         split_ff    <= split_in;
         error_ff    <= error_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= hps_pkg::POS_W'(hps_pkg::MAX_LEN + 1))
      else $error("byte counter past saturation");

   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (fire && has_verdict) |=> (position_ff == '0 && phase_ff == PH_START && !error_ff))
      else $error("parse state not cleared after verdict");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (verdict.status == hps_pkg::STATUS_BAD) |->
      (verdict.host_length == '0 && verdict.port_offset == '0 &&
       verdict.port_length == '0 && !verdict.has_port && !verdict.host_offset))
      else $error("bad verdict carries nonzero fields");

   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PLAIN_PORT || phase_ff == PH_AFTER_RB || phase_ff == PH_BR_PORT)
      |-> (split_ff < position_ff))
      else $error("split point not behind counter");

endmodule
`default_nettype wire

// ===== src/host_port_splitter_top.sv =====
// Top level of the host/port splitter: request register, parser, response register.
//
// Usage:
//   The req channel carries an authority string ("host[:port]" or "[host][:port]")
//   one byte per request; last marks the final byte. A request with empty_req set
//   stands for a zero-length string and yields a bad verdict at once, dropping any
//   partially received string.
//   The rsp channel returns one verdict per string: status, host offset/length,
//   port offset/length and has_port. A bad verdict has all other fields zero.
//   Strings longer than MAX_LEN bytes are bad; their bytes are still consumed.
// Timing:
//   One request per cycle sustained, unless a final byte waits on a stalled rsp. The
//   final byte goes into the request register, then its verdict into the response
//   register, which drives rsp.valid; between them sit compares and offset adders.
// Reset:
//   Synchronous, active high. Clears both channel valids and the parse state.
// Backpressure:
//   When rsp stalls, a held verdict stays in the response register; non-final
//   bytes keep flowing into the parser, and a second final byte waits in the
//   request register, which then drops req.ready.
`default_nettype none
module host_port_splitter_top (
   input wire logic  clock,
   input wire logic  reset,
   hps_req_if.sink   req_ch,
   hps_rsp_if.source rsp_ch
);

   logic                 req_valid_ff, req_valid_in;
   hps_pkg::item_type    req_item_ff, req_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hps_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic                 advance;
   logic                 has_verdict;
   hps_pkg::verdict_type verdict;

   // Parser consumes the held request unless its verdict has nowhere to go
   assign advance = req_valid_ff && (!has_verdict || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;

   hps_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (req_item_ff),
      .has_verdict (has_verdict),
      .verdict     (verdict)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_ch.ready) begin
         req_valid_in          = req_ch.valid;
         req_item_in.data_byte = req_ch.data_byte;
         req_item_in.last      = req_ch.last;
         req_item_in.empty_req = req_ch.empty_req;
      end
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_verdict_in = rsp_verdict_ff;
      if (advance && has_verdict) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_item_ff    <= req_item_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_verdict_ff.status;
   assign rsp_ch.host_offset = rsp_verdict_ff.host_offset;
   assign rsp_ch.host_length = rsp_verdict_ff.host_length;
   assign rsp_ch.port_offset = rsp_verdict_ff.port_offset;
   assign rsp_ch.port_length = rsp_verdict_ff.port_length;
   assign rsp_ch.has_port    = rsp_verdict_ff.has_port;

   // A final byte must wait while an earlier verdict is still unclaimed
   a_hold_final: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && has_verdict && rsp_valid_ff && !rsp_ch.ready) |=> req_valid_ff)
      else $error("final byte dropped while response stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !advance || !has_verdict)
      else $error("verdict overwritten while stalled");

endmodule
`default_nettype wire

// ===== verif/hps_checker.sv =====
// Scoreboard of the host/port splitter: predicts each verdict and checks the rsp channel.
`timescale 1ns / 100ps
module hps_checker (
   input  wire logic clock,
   input  wire logic reset,
   hps_req_if        req_ch,
   hps_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending_verdicts
);

   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_BR_HOST,
      SCAN_AFTER_RB,
      SCAN_BR_PORT,
      SCAN_PLAIN_HOST,
      SCAN_PLAIN_PORT
   } scan_phase_type;

   scan_phase_type scan_phase;
   int unsigned    byte_count;   // saturates at MAX_LEN + 1
   int unsigned    split_at;     // offset of ']' or of the splitting ':'
   bit             syntax_bad;

   hps_pkg::verdict_type expected_verdicts[$];

   initial begin
      fail_count       = 0;
      pending_verdicts = 0;
   end

   function automatic void clear_scan();
      scan_phase = SCAN_START;
      byte_count = 0;
      split_at   = 0;
      syntax_bad = 1'b0;
   endfunction

   // Advances the parse by one request; returns 1 when a verdict is due.
   function automatic bit scan_byte(input hps_pkg::item_type it,
                                    output hps_pkg::verdict_type v);
      v        = '0;
      v.status = hps_pkg::STATUS_BAD;
      if (it.empty_req) begin
         clear_scan();
         return 1'b1;
      end
      if (byte_count >= hps_pkg::MAX_LEN)
         syntax_bad = 1'b1;
      if (!syntax_bad) begin
         case (scan_phase)
            SCAN_START: begin
               if (it.data_byte == hps_pkg::CHAR_LBRACKET)
                  scan_phase = SCAN_BR_HOST;
               else if (it.data_byte == hps_pkg::CHAR_COLON)
                  syntax_bad = 1'b1;
               else
                  scan_phase = SCAN_PLAIN_HOST;
            end
            SCAN_BR_HOST: begin
               if (it.data_byte == hps_pkg::CHAR_RBRACKET) begin
                  if (byte_count == 1) begin
                     syntax_bad = 1'b1;
                  end else begin
                     split_at   = byte_count;
                     scan_phase = SCAN_AFTER_RB;
                  end
               end
            end
            SCAN_AFTER_RB: begin
               if (it.data_byte == hps_pkg::CHAR_COLON)
                  scan_phase = SCAN_BR_PORT;
               else
                  syntax_bad = 1'b1;
            end
            SCAN_PLAIN_HOST: begin
               if (it.data_byte == hps_pkg::CHAR_COLON) begin
                  split_at   = byte_count;
                  scan_phase = SCAN_PLAIN_PORT;
               end
            end
            default: ;
         endcase
      end
      if (byte_count <= hps_pkg::MAX_LEN)
         byte_count++;
      if (!it.last)
         return 1'b0;

      if (!syntax_bad) begin
         case (scan_phase)
            SCAN_AFTER_RB: begin
               v.status      = hps_pkg::STATUS_OK;
               v.host_offset = 1'b1;
               v.host_length = hps_pkg::LEN_W'(split_at - 1);
            end
            SCAN_BR_PORT: begin
               v.status      = hps_pkg::STATUS_OK;
               v.host_offset = 1'b1;
               v.host_length = hps_pkg::LEN_W'(split_at - 1);
               v.port_offset = hps_pkg::LEN_W'(split_at + 2);
               v.port_length = hps_pkg::LEN_W'(byte_count - split_at - 2);
               v.has_port    = 1'b1;
            end
            SCAN_PLAIN_HOST: begin
               v.status      = hps_pkg::STATUS_OK;
               v.host_length = hps_pkg::LEN_W'(byte_count);
            end
            SCAN_PLAIN_PORT: begin
               v.status      = hps_pkg::STATUS_OK;
               v.host_length = hps_pkg::LEN_W'(split_at);
               v.port_offset = hps_pkg::LEN_W'(split_at + 1);
               v.port_length = hps_pkg::LEN_W'(byte_count - split_at - 1);
               v.has_port    = 1'b1;
            end
            default: ;   // open bracket never closed
         endcase
      end
      clear_scan();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got_val,
                                  input longint want_val);
      $display("%0t ns: verdict mismatch on %s: got %0d, expected %0d",
               $time, what, got_val, want_val);
      fail_count++;
   endtask

   always @(posedge clock) begin
      hps_pkg::verdict_type got;
      hps_pkg::verdict_type want;
      hps_pkg::item_type    req_item;
      if (reset) begin
         clear_scan();
         expected_verdicts.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{status:      rsp_ch.status,
                    host_offset: rsp_ch.host_offset,
                    host_length: rsp_ch.host_length,
                    port_offset: rsp_ch.port_offset,
                    port_length: rsp_ch.port_length,
                    has_port:    rsp_ch.has_port};
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict with none outstanding", got, 0);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.host_offset !== want.host_offset)
                  report_mismatch("host_offset", got.host_offset, want.host_offset);
               if (got.host_length !== want.host_length)
                  report_mismatch("host_length", got.host_length, want.host_length);
               if (got.port_offset !== want.port_offset)
                  report_mismatch("port_offset", got.port_offset, want.port_offset);
               if (got.port_length !== want.port_length)
                  report_mismatch("port_length", got.port_length, want.port_length);
               if (got.has_port !== want.has_port)
                  report_mismatch("has_port", got.has_port, want.has_port);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_item = '{data_byte: req_ch.data_byte,
                         last:      req_ch.last,
                         empty_req: req_ch.empty_req};
            if (scan_byte(req_item, want))
               expected_verdicts.push_back(want);
         end
      end
      pending_verdicts = expected_verdicts.size();
   end

endmodule

// ===== verif/tb_host_port_splitter_top.sv =====
// Testbench top of the host/port splitter: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_host_port_splitter_top;

   typedef logic [7:0] octet_q_type[$];

   logic clock;
   logic reset;

   hps_req_if req_ch();
   hps_rsp_if rsp_ch();

   int fail_count;
   int pending_verdicts;

   // Chance in percent that the sender skips a cycle / the receiver stalls one.
   int send_gap_pct;
   int recv_stall_pct;

   // Requests accepted so far; the random part stops on this count.
   int requests_sent;

   host_port_splitter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hps_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .fail_count       (fail_count),
      .pending_verdicts (pending_verdicts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run (heavy stalls).
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   // Receiver: ready changes on the falling edge only, one update per cycle.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request: random gap cycles first, then hold valid until accepted.
   // Valid is only ever raised or lowered on a falling edge, never both in one step.
   task automatic send_request(input logic [7:0] b, input logic l, input logic e);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last      <= l;
      req_ch.empty_req <= e;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_string(input octet_q_type s);
      foreach (s[i])
         send_request(s[i], i == s.size() - 1, 1'b0);
   endtask

   task automatic send_text(input string t);
      octet_q_type q;
      foreach (t[i])
         q.push_back(t[i]);
      send_string(q);
   endtask

   // Zero-length string; data and last are don't-care, so they get random values.
   task automatic send_empty();
      send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
   endtask

   // Host byte: mostly hostname text, sometimes any byte; never stop_char.
   function automatic logic [7:0] host_char(input logic [7:0] stop_char);
      string       alphabet;
      logic [7:0]  c;
      alphabet = "abcdefghijklmnopqrstuvwxyz0123456789.-";
      do begin
         if ($urandom_range(99) < 80)
            c = alphabet[$urandom_range(alphabet.len() - 1)];
         else
            c = 8'($urandom_range(255));
      end while (c == stop_char);
      return c;
   endfunction

   // Port text is not checked by the block, so stray bytes are fair game.
   function automatic logic [7:0] port_char();
      if ($urandom_range(99) < 90)
         return 8'h30 + 8'($urandom_range(9));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      octet_q_type authority;
      int          shape;
      int          host_bytes;
      int          port_bytes;
      int          stage_start;

      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last      = 1'b0;
      req_ch.empty_req = 1'b0;
      rsp_ch.ready     = 1'b0;
      send_gap_pct     = 21;
      recv_stall_pct   = 73;
      requests_sent    = 0;

      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- Directed part ----
      send_empty();                        // zero-length string
      send_text("a");                      // shortest plain host
      send_text("h:80");                   // plain host and port
      send_text(":80");                    // leading colon is bad
      send_text(":");
      send_text("h:");                     // colon with empty port
      send_text("a:b:c");                  // first colon splits
      send_text("]a[");                    // brackets only matter up front
      send_text("[::1]");                  // bracketed host, no port
      send_text("[::1]:443");              // bracketed host and port
      send_text("[a]:");                   // bracketed, empty port
      send_text("[]");                     // empty brackets are bad
      send_text("[]:1");
      send_text("[ab");                    // closing bracket missing
      send_text("[a]x");                   // text after closing bracket
      send_text("[a]]");
      authority = {8'h00, 8'hFF, hps_pkg::CHAR_COLON, 8'hFF, 8'h00};
      send_string(authority);              // extreme byte values
      // Partial string dropped by an empty request, then a fresh one.
      send_request("a", 1'b0, 1'b0);
      send_request("b", 1'b0, 1'b0);
      send_empty();
      send_text("c");

      // ---- Random part, three idling stages ----
      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin send_gap_pct = 21; recv_stall_pct = 73; end
            1: begin send_gap_pct = 73; recv_stall_pct = 21; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         stage_start = requests_sent;
         while (requests_sent - stage_start < 212) begin
            authority = {};
            shape     = $urandom_range(99);
            if ($urandom_range(9) == 0)
               host_bytes = $urandom_range(7, 40);
            else
               host_bytes = $urandom_range(1, 6);
            port_bytes = $urandom_range(0, 5);

            if (shape < 35) begin
               // host[:port]
               repeat (host_bytes) authority.push_back(host_char(hps_pkg::CHAR_COLON));
               if (authority[0] == hps_pkg::CHAR_LBRACKET)
                  authority[0] = "a";
               if ($urandom_range(1)) begin
                  authority.push_back(hps_pkg::CHAR_COLON);
                  repeat (port_bytes) authority.push_back(port_char());
               end
               send_string(authority);
            end else if (shape < 65) begin
               // [host][:port], with an occasional flaw
               authority.push_back(hps_pkg::CHAR_LBRACKET);
               if ($urandom_range(19) == 0)
                  host_bytes = 0;
               repeat (host_bytes) begin
                  if ($urandom_range(3) == 0)
                     authority.push_back(hps_pkg::CHAR_COLON);
                  else
                     authority.push_back(host_char(hps_pkg::CHAR_RBRACKET));
               end
               if ($urandom_range(99) >= 12)
                  authority.push_back(hps_pkg::CHAR_RBRACKET);
               case ($urandom_range(9))
                  0, 1, 2: ;
                  3: begin
                     authority.push_back(host_char(hps_pkg::CHAR_COLON));
                     repeat (port_bytes) authority.push_back(port_char());
                  end
                  default: begin
                     authority.push_back(hps_pkg::CHAR_COLON);
                     repeat (port_bytes) authority.push_back(port_char());
                  end
               endcase
               send_string(authority);
            end else if (shape < 72) begin
               // leading colon
               authority.push_back(hps_pkg::CHAR_COLON);
               repeat (port_bytes) authority.push_back(port_char());
               send_string(authority);
            end else if (shape < 82) begin
               // empty request, sometimes cutting a string short
               if ($urandom_range(1)) begin
                  repeat ($urandom_range(1, 4))
                     send_request(host_char(hps_pkg::CHAR_COLON), 1'b0, 1'b0);
               end
               send_empty();
            end else begin
               // raw noise
               repeat ($urandom_range(1, 8)) authority.push_back(8'($urandom_range(255)));
               send_string(authority);
            end
         end
         // Hold off the sender until every verdict of this stage is back.
         @(negedge clock);
         req_ch.valid <= 1'b0;
         wait (pending_verdicts == 0);
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_verdicts == 0);
      // Response path is two registers deep; leave room for a stray verdict.
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
